@@ design/pcs_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the priority candidate selector.
// No dependencies; used by pcs_ctrl, pcs_datapath and the top level.
package pcs_pkg;

	localparam int unsigned ID_W     = 16;
	localparam int unsigned PRIO_W   = 8;
	localparam int unsigned ORDER_W  = 32;
	localparam int unsigned COUNT_W  = 5;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned WORD_W   = ID_W + PRIO_W + ORDER_W;

	// Request kinds
	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_REMOVE = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		STAT_INSERTED = 3'd0,
		STAT_PRESENT  = 3'd1,
		STAT_FULL     = 3'd2,
		STAT_REMOVED  = 3'd3,
		STAT_NOTFOUND = 3'd4,
		STAT_NULL     = 3'd5
	} status_code_t;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_DRAIN  = 4'b0100,
		ST_FINISH = 4'b1000
	} ctrl_state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;    // capture request, clear scan results
		logic issue;   // read one slot, advance the scan address
		logic finish;  // resolve the request, update the table, emit result
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic scan_last;  // address on the read port is the last slot
	} dp_stat_t;

endpackage

@@ design/priority_candidate_selector_core.sv @@
`timescale 1ns / 1ps
// Top level of the priority candidate selector: controller plus datapath.
// Depends on pcs_pkg, pcs_ctrl, pcs_datapath (and pcs_ram below it).
//
//  channel   | handshake         | payload
//  ----------+-------------------+---------------------------------------------
//  request   | start / busy      | kind, target_id, target_priority
//  result    | done (1 cycle)    | best_valid, best_id, held_count, status
//
// A request is taken at a rising edge with start high and busy low.
// Each request goes through these steps from that edge to the done strobe:
// a read of every slot through the single read port of the slot RAM, a drain
// step for the last read to land and a finish step that updates the
// table and registers the result; done follows in the next cycle. busy drops
// in the done cycle, so a new request may be taken at the same edge that takes
// the result.
// Reset clears the valid bits, the entry count and the order counter at once;
// the slot RAM itself needs no clearing pass. The receiver cannot stall.
module priority_candidate_selector_core #(
	parameter int unsigned ENTRIES = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              kind,
	input  logic [pcs_pkg::ID_W-1:0]          target_id,
	input  logic signed [pcs_pkg::PRIO_W-1:0] target_priority,
	output logic                              done,
	output logic                              best_valid,
	output logic [pcs_pkg::ID_W-1:0]          best_id,
	output logic [pcs_pkg::COUNT_W-1:0]       held_count,
	output logic [pcs_pkg::STATUS_W-1:0]      status
);

	pcs_pkg::cmd_t     cmd;
	pcs_pkg::dp_stat_t stat;

	// Controller: sequence the scan and the finish step of each request
	pcs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Datapath: hold the table, scan it, pick the best and drive the result
	pcs_datapath #(
		.ENTRIES (ENTRIES)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.kind            (kind),
		.target_id       (target_id),
		.target_priority (target_priority),
		.done            (done),
		.best_valid      (best_valid),
		.best_id         (best_id),
		.held_count      (held_count),
		.status          (status)
	);

	// A taken request makes the block busy on the next cycle
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request taken but block not busy");

	// The done strobe only follows a busy cycle
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("done without a request in flight");

	// A best candidate is reported exactly when the table is not empty
	a_valid_vs_count: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (best_valid == (held_count != '0)))
		else $error("best_valid disagrees with held_count");

	// A reported best candidate never carries the null id
	a_best_not_null: assert property (@(posedge clk) disable iff (!arst_n)
		done && best_valid |-> best_id != '0)
		else $error("null id reported as best");

endmodule

@@ design/pcs_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pcs_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ design/pcs_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencing state machine: idle, slot scan, read drain, finish.
// Depends on pcs_pkg for the state, command and status types.
module pcs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  pcs_pkg::dp_stat_t stat,
	output pcs_pkg::cmd_t     cmd,
	output logic              busy
);

	pcs_pkg::ctrl_state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pcs_pkg::ST_IDLE: begin
				if (start) begin
					state_d = pcs_pkg::ST_SCAN;
				end
			end
			pcs_pkg::ST_SCAN: begin
				if (stat.scan_last) begin
					state_d = pcs_pkg::ST_DRAIN;
				end
			end
			pcs_pkg::ST_DRAIN:  state_d = pcs_pkg::ST_FINISH;
			pcs_pkg::ST_FINISH: state_d = pcs_pkg::ST_IDLE;
			default:            state_d = pcs_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign cmd.load   = (state_q == pcs_pkg::ST_IDLE) && start;
	assign cmd.issue  = (state_q == pcs_pkg::ST_SCAN);
	assign cmd.finish = (state_q == pcs_pkg::ST_FINISH);
	assign busy       = (state_q != pcs_pkg::ST_IDLE);

endmodule

@@ design/pcs_datapath.sv @@
`timescale 1ns / 1ps
// Candidate table, slot scan, best selection and result registers.
// Depends on pcs_pkg and pcs_ram.
module pcs_datapath #(
	parameter int unsigned ENTRIES = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  pcs_pkg::cmd_t                        cmd,
	output pcs_pkg::dp_stat_t                    stat,
	input  logic                                 kind,
	input  logic [pcs_pkg::ID_W-1:0]             target_id,
	input  logic signed [pcs_pkg::PRIO_W-1:0]    target_priority,
	output logic                                 done,
	output logic                                 best_valid,
	output logic [pcs_pkg::ID_W-1:0]             best_id,
	output logic [pcs_pkg::COUNT_W-1:0]          held_count,
	output logic [pcs_pkg::STATUS_W-1:0]         status
);

	localparam int unsigned AW = $clog2(ENTRIES);
	localparam int unsigned CW = $clog2(ENTRIES + 1);
	localparam int unsigned HW = (CW > pcs_pkg::COUNT_W) ? CW : pcs_pkg::COUNT_W;
	localparam int unsigned OW = pcs_pkg::ORDER_W;
	localparam int unsigned PW = pcs_pkg::PRIO_W;
	localparam int unsigned IW = pcs_pkg::ID_W;

	// a beats b: higher priority, then earlier order, then lower slot
	function automatic logic better(
		input logic signed [PW-1:0] pa, input logic [OW-1:0] oa, input logic [AW-1:0] sa,
		input logic signed [PW-1:0] pb, input logic [OW-1:0] ob, input logic [AW-1:0] sb
	);
		return (pa > pb) || ((pa == pb) && ((oa < ob) || ((oa == ob) && (sa < sb))));
	endfunction

	// Request capture
	logic                 kind_q;
	logic [IW-1:0]        tid_q;
	logic signed [PW-1:0] tprio_q;

	// Table state
	logic [ENTRIES-1:0] used_q;
	logic [CW-1:0]      count_q;
	logic [OW-1:0]      order_q;

	// Scan
	logic [AW-1:0] addr_q;
	logic          eval_s1;
	logic [AW-1:0] index_s1;
	logic [pcs_pkg::WORD_W-1:0] rdata;
	logic [IW-1:0]        r_id;
	logic signed [PW-1:0] r_prio;
	logic [OW-1:0]        r_order;

	// Scan results
	logic                 match_q;
	logic [AW-1:0]        match_slot_q;
	logic signed [PW-1:0] match_prio_q;
	logic [OW-1:0]        match_order_q;
	logic                 free_found_q;
	logic [AW-1:0]        free_slot_q;
	logic                 bex_valid_q;
	logic [AW-1:0]        bex_slot_q;
	logic signed [PW-1:0] bex_prio_q;
	logic [OW-1:0]        bex_order_q;
	logic [IW-1:0]        bex_id_q;

	logic hit, is_match, take_best, take_free;

	// Finish
	logic                  is_null, do_insert, do_remove;
	logic                  xv;
	logic signed [PW-1:0]  xp;
	logic [OW-1:0]         xo;
	logic [AW-1:0]         xs;
	logic [IW-1:0]         xid;
	logic                  pick_x;
	logic [OW-1:0]         order_next;
	logic [CW-1:0]         count_next;
	logic [HW-1:0]         count_ext;
	pcs_pkg::status_code_t code;

	logic done_q, best_valid_q;
	logic [IW-1:0]                  best_id_q;
	logic [pcs_pkg::COUNT_W-1:0]    held_q;
	logic [pcs_pkg::STATUS_W-1:0]   status_q;

	pcs_ram #(
		.WIDTH (pcs_pkg::WORD_W),
		.DEPTH (ENTRIES)
	) u_slots (
		.clk   (clk),
		.we    (cmd.finish && do_insert),
		.waddr (free_slot_q),
		.wdata ({tid_q, tprio_q, order_next}),
		.re    (cmd.issue),
		.raddr (addr_q),
		.rdata (rdata)
	);

	assign r_id    = rdata[pcs_pkg::WORD_W-1 -: IW];
	assign r_prio  = rdata[OW +: PW];
	assign r_order = rdata[OW-1:0];

	assign stat.scan_last = (addr_q == AW'(ENTRIES - 1));

	assign hit       = eval_s1 && used_q[index_s1];
	assign is_match  = hit && (r_id == tid_q);
	assign take_best = hit && !is_match && (!bex_valid_q
		|| better(r_prio, r_order, index_s1, bex_prio_q, bex_order_q, bex_slot_q));
	assign take_free = eval_s1 && !used_q[index_s1] && !free_found_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= kind;
			tid_q   <= target_id;
			tprio_q <= target_priority;
		end
		index_s1 <= addr_q;
		if (is_match) begin
			match_slot_q  <= index_s1;
			match_prio_q  <= r_prio;
			match_order_q <= r_order;
		end
		if (take_free) begin
			free_slot_q <= index_s1;
		end
		if (take_best) begin
			bex_slot_q  <= index_s1;
			bex_prio_q  <= r_prio;
			bex_order_q <= r_order;
			bex_id_q    <= r_id;
		end
		if (cmd.finish) begin
			best_id_q <= pick_x ? xid : (bex_valid_q ? bex_id_q : '0);
			held_q    <= (count_ext > HW'(31)) ? pcs_pkg::COUNT_W'(31)
				: count_ext[pcs_pkg::COUNT_W-1:0];
			status_q  <= code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q       <= '0;
			eval_s1      <= 1'b0;
			match_q      <= 1'b0;
			free_found_q <= 1'b0;
			bex_valid_q  <= 1'b0;
			used_q       <= '0;
			count_q      <= '0;
			order_q      <= '0;
			done_q       <= 1'b0;
			best_valid_q <= 1'b0;
		end else begin
			eval_s1 <= cmd.issue;
			if (cmd.load) begin
				addr_q       <= '0;
				match_q      <= 1'b0;
				free_found_q <= 1'b0;
				bex_valid_q  <= 1'b0;
			end else begin
				if (cmd.issue) begin
					addr_q <= addr_q + AW'(1);
				end
				if (is_match) begin
					match_q <= 1'b1;
				end
				if (take_free) begin
					free_found_q <= 1'b1;
				end
				if (take_best) begin
					bex_valid_q <= 1'b1;
				end
			end
			done_q <= cmd.finish;
			if (cmd.finish) begin
				best_valid_q <= xv || bex_valid_q;
				count_q      <= count_next;
				if (do_insert) begin
					used_q[free_slot_q] <= 1'b1;
					order_q             <= order_next;
				end
				if (do_remove) begin
					used_q[match_slot_q] <= 1'b0;
				end
			end
		end
	end

	// Resolve the request from the scan results
	assign order_next = (&order_q) ? order_q : order_q + OW'(1);
	assign is_null    = (tid_q == '0);
	assign do_insert  = !is_null && (kind_q == pcs_pkg::KIND_INSERT) && !match_q && free_found_q;
	assign do_remove  = !is_null && (kind_q == pcs_pkg::KIND_REMOVE) && match_q;

	always_comb begin
		xv  = 1'b0;
		xp  = match_prio_q;
		xo  = match_order_q;
		xs  = match_slot_q;
		xid = tid_q;
		count_next = count_q;
		priority if (is_null) begin
			code = pcs_pkg::STAT_NULL;
		end else if (kind_q == pcs_pkg::KIND_INSERT) begin
			priority if (match_q) begin
				code = pcs_pkg::STAT_PRESENT;
				xv   = 1'b1;
			end else if (!free_found_q) begin
				code = pcs_pkg::STAT_FULL;
			end else begin
				code = pcs_pkg::STAT_INSERTED;
				xv   = 1'b1;
				xp   = tprio_q;
				xo   = order_next;
				xs   = free_slot_q;
				count_next = count_q + CW'(1);
			end
		end else begin
			if (match_q) begin
				code = pcs_pkg::STAT_REMOVED;
				count_next = count_q - CW'(1);
			end else begin
				code = pcs_pkg::STAT_NOTFOUND;
			end
		end
		pick_x    = xv && (!bex_valid_q
			|| better(xp, xo, xs, bex_prio_q, bex_order_q, bex_slot_q));
		count_ext = HW'(count_next);
	end

	assign done       = done_q;
	assign best_valid = best_valid_q;
	assign best_id    = best_id_q;
	assign held_count = held_q;
	assign status     = status_q;

endmodule

@@ verif/pcs_selection_checker.sv @@
`timescale 1ns / 1ps
// Checker for priority_candidate_selector_core: tracks the candidate table and
// compares every done strobe with the predicted selection. Depends on pcs_pkg.
module pcs_selection_checker #(
	parameter int unsigned ENTRIES = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              busy,
	input  logic                              kind,
	input  logic [pcs_pkg::ID_W-1:0]          target_id,
	input  logic signed [pcs_pkg::PRIO_W-1:0] target_priority,
	input  logic                              done,
	input  logic                              best_valid,
	input  logic [pcs_pkg::ID_W-1:0]          best_id,
	input  logic [pcs_pkg::COUNT_W-1:0]       held_count,
	input  logic [pcs_pkg::STATUS_W-1:0]      status,
	output int                                mismatches,
	output int                                outstanding
);
	import pcs_pkg::*;

	typedef struct packed {
		logic                best_valid;
		logic [ID_W-1:0]     best_id;
		logic [COUNT_W-1:0]  held;
		status_code_t        status;
	} selection_t;

	// Shadow copy of the candidate table
	logic                      occupied  [ENTRIES];
	logic [ID_W-1:0]           slot_key  [ENTRIES];
	logic signed [PRIO_W-1:0]  slot_rank [ENTRIES];
	logic [ORDER_W-1:0]        slot_age  [ENTRIES];
	logic [ORDER_W-1:0]        stamp;

	selection_t selection_q[$];
	int fail_tally = 0;
	int queued = 0;

	assign mismatches  = fail_tally;
	assign outstanding = queued;

	task automatic report(input string msg);
		$display("%0t ns: MISMATCH %s", $time, msg);
		fail_tally++;
	endtask

	// Apply one request to the shadow table and return the selection it yields
	function automatic selection_t apply_request(input logic req_kind,
			input logic [ID_W-1:0] req_id, input logic signed [PRIO_W-1:0] req_prio);
		selection_t res;
		int hit;
		int free_slot;
		int top;
		int unsigned cnt;
		hit = -1;
		free_slot = -1;
		top = -1;
		cnt = 0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (occupied[i] && slot_key[i] == req_id && hit < 0)
				hit = i;
			if (!occupied[i] && free_slot < 0)
				free_slot = i;
		end
		if (req_id == '0) begin
			res.status = STAT_NULL;
		end else if (req_kind == KIND_INSERT) begin
			if (hit >= 0) begin
				res.status = STAT_PRESENT;
			end else if (free_slot < 0) begin
				res.status = STAT_FULL;
			end else begin
				if (stamp != '1)
					stamp++;
				occupied[free_slot]  = 1'b1;
				slot_key[free_slot]  = req_id;
				slot_rank[free_slot] = req_prio;
				slot_age[free_slot]  = stamp;
				res.status = STAT_INSERTED;
			end
		end else begin
			if (hit >= 0) begin
				occupied[hit] = 1'b0;
				res.status = STAT_REMOVED;
			end else begin
				res.status = STAT_NOTFOUND;
			end
		end
		for (int i = 0; i < ENTRIES; i++) begin
			if (occupied[i]) begin
				cnt++;
				if (top < 0)
					top = i;
				else if (slot_rank[i] > slot_rank[top] ||
						(slot_rank[i] == slot_rank[top] && slot_age[i] < slot_age[top]))
					top = i;
			end
		end
		if (cnt > 31)
			cnt = 31;
		res.held       = cnt[COUNT_W-1:0];
		res.best_valid = (top >= 0);
		res.best_id    = (top >= 0) ? slot_key[top] : '0;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		selection_t want;
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++)
				occupied[i] = 1'b0;
			stamp = '0;
			selection_q.delete();
			queued = 0;
		end else begin
			if (done) begin
				if (selection_q.size() == 0) begin
					report("result with no request pending");
				end else begin
					want = selection_q.pop_front();
					if (best_valid !== want.best_valid)
						report($sformatf("best_valid got %b expected %b",
							best_valid, want.best_valid));
					if (best_id !== want.best_id)
						report($sformatf("best_id got %h expected %h", best_id, want.best_id));
					if (held_count !== want.held)
						report($sformatf("held_count got %0d expected %0d",
							held_count, want.held));
					if (status !== want.status)
						report($sformatf("status got %0d expected %s",
							status, want.status.name()));
				end
			end
			if (start && !busy)
				selection_q.push_back(apply_request(kind, target_id, target_priority));
			queued = selection_q.size();
		end
	end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// Testbench top for priority_candidate_selector_core: drives insert and remove
// requests and gives the verdict. Depends on pcs_pkg and pcs_selection_checker.
module tb;
	import pcs_pkg::*;

	localparam int unsigned ENTRIES    = 16;
	localparam int          CLK_PERIOD = 20;
	localparam int          POOL_SIZE  = 24;

	logic                      clk;
	logic                      arst_n          = 1'b0;
	logic                      start           = 1'b0;
	logic                      kind            = KIND_INSERT;
	logic [ID_W-1:0]           target_id       = '0;
	logic signed [PRIO_W-1:0]  target_priority = '0;
	logic                      busy;
	logic                      done;
	logic                      best_valid;
	logic [ID_W-1:0]           best_id;
	logic [COUNT_W-1:0]        held_count;
	logic [STATUS_W-1:0]       status;
	int                        mismatches;
	int                        outstanding;

	// A small pool of ids keeps duplicates, hits on remove and a full table
	// common; a few ids outside the pool toggle every id bit.
	logic [ID_W-1:0]           id_pool [POOL_SIZE];

	priority_candidate_selector_core #(
		.ENTRIES(ENTRIES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.target_id(target_id),
		.target_priority(target_priority),
		.done(done),
		.best_valid(best_valid),
		.best_id(best_id),
		.held_count(held_count),
		.status(status)
	);

	pcs_selection_checker #(
		.ENTRIES(ENTRIES)
	) u_selection_check (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.target_id(target_id),
		.target_priority(target_priority),
		.done(done),
		.best_valid(best_valid),
		.best_id(best_id),
		.held_count(held_count),
		.status(status),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Present one request at the falling edge and hold it until a rising edge
	// sees busy low. start stays high afterwards so back-to-back requests need
	// only one assignment per edge.
	task automatic send_request(input logic req_kind, input logic [ID_W-1:0] req_id,
			input logic signed [PRIO_W-1:0] req_prio);
		@(negedge clk);
		start           <= 1'b1;
		kind            <= req_kind;
		target_id       <= req_id;
		target_priority <= req_prio;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Drop start for a number of cycles
	task automatic hold_off(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	// Random requests: each block of 50 picks its own insert share, so the
	// table sweeps between empty and full. Priorities mostly sit near zero
	// to make ties frequent.
	task automatic run_random(input int items, input int idle_pct);
		int insert_pct;
		int roll;
		logic req_kind;
		logic [ID_W-1:0] req_id;
		logic signed [PRIO_W-1:0] req_prio;
		insert_pct = 50;
		for (int n = 0; n < items; n++) begin
			if (n % 50 == 0)
				insert_pct = int'($urandom_range(20, 85));
			roll = int'($urandom_range(0, 99));
			if (roll < 3)
				req_id = '0;
			else if (roll < 10)
				req_id = ID_W'($urandom_range(1, 65535));
			else
				req_id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
			req_kind = ($urandom_range(0, 99) < insert_pct) ? KIND_INSERT : KIND_REMOVE;
			if ($urandom_range(0, 3) == 0)
				req_prio = PRIO_W'($urandom_range(0, 255));
			else
				req_prio = PRIO_W'(int'($urandom_range(0, 4)) - 2);
			send_request(req_kind, req_id, req_prio);
			if ($urandom_range(0, 99) < idle_pct)
				hold_off(int'($urandom_range(1, 24)));
		end
	endtask

	initial begin
		int waited;
		for (int i = 0; i < POOL_SIZE; i++)
			id_pool[i] = ID_W'($urandom_range(1, 65535));

		// Hold reset, then release it at a falling edge
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: empty table, null ids, extremes of id and priority
		send_request(KIND_REMOVE, 16'h0005, 8'sd0);
		send_request(KIND_INSERT, 16'h0000, 8'sd5);
		send_request(KIND_REMOVE, 16'h0000, 8'sd0);
		send_request(KIND_INSERT, 16'hFFFF, -8'sd128);
		send_request(KIND_INSERT, 16'h0001, 8'sd127);
		// Equal priority: the earlier entry must stay the best
		send_request(KIND_INSERT, 16'h0002, 8'sd127);
		// Duplicate insert keeps the stored priority
		send_request(KIND_INSERT, 16'h0001, -8'sd1);
		send_request(KIND_REMOVE, 16'h0001, 8'sd0);
		// Fill the table, then overflow it
		for (int k = 0; k < 14; k++)
			send_request(KIND_INSERT, ID_W'(16'h0100 + k), PRIO_W'($urandom_range(0, 255)));
		send_request(KIND_INSERT, 16'h8000, 8'sd100);
		// Free slot zero, so that the next insert lands there
		send_request(KIND_REMOVE, 16'hFFFF, 8'sd0);
		send_request(KIND_INSERT, 16'hAAAA, 8'sd0);

		// Random: sender idles rarely, then mostly, then never
		run_random(670, 7);
		run_random(670, 80);
		run_random(670, 0);
		hold_off(1);

		// Drain, bounded, then let the pipeline settle
		waited = 0;
		while (outstanding != 0 && waited < 200) begin
			@(posedge clk);
			waited++;
		end
		repeat (ENTRIES + 5) @(posedge clk);

		if (mismatches == 0 && outstanding == 0)
			$display("priority_candidate_selector_core verification clean");
		else
			$display("priority_candidate_selector_core verification failed");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run
	initial begin
		#(CLK_PERIOD * 1000000);
		$display("priority_candidate_selector_core verification failed");
		$finish;
	end

endmodule
